@@ design/vfo_tuning_controller_unit_macros.svh @@
// assertion macros shared by the vfo tuning controller checker
// needs a clk and an rst_n in the scope where the macros are used
`ifndef VFO_TUNING_CONTROLLER_UNIT_MACROS_SVH
`define VFO_TUNING_CONTROLLER_UNIT_MACROS_SVH

// property checked only outside reset
`define VFO_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define VFO_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/vfo_pkg.sv @@
// shared types, codes, constants and tables of the vfo tuning controller
// no dependencies
package vfo_pkg;

  localparam int unsigned OP_W       = 3;
  localparam int unsigned FREQ_W     = 28;
  localparam int unsigned STEP_W     = 20;
  localparam int unsigned STEP_IDX_W = 3;
  localparam int unsigned BAND_W     = 5;
  localparam int unsigned IF_W       = 16;
  localparam int unsigned SYNTH_W    = 35;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 28;

  // operation codes
  localparam logic [OP_W-1:0] OP_REPORT    = 3'd0;
  localparam logic [OP_W-1:0] OP_TUNE_UP   = 3'd1;
  localparam logic [OP_W-1:0] OP_TUNE_DOWN = 3'd2;
  localparam logic [OP_W-1:0] OP_NEXT_STEP = 3'd3;
  localparam logic [OP_W-1:0] OP_NEXT_BAND = 3'd4;
  localparam logic [OP_W-1:0] OP_SET_MODE  = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IF_KHZ        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LIMIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LIMIT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNTH_PRESENT = 2'd3;

  // reset values
  localparam logic [IF_W-1:0]       IF_KHZ_RST      = 16'd455;
  localparam logic [FREQ_W-1:0]     LOWER_LIMIT_RST = 28'd10000;
  localparam logic [FREQ_W-1:0]     UPPER_LIMIT_RST = 28'd225000000;
  localparam logic [FREQ_W-1:0]     FREQ_RST        = 28'd10000000;
  localparam logic [STEP_IDX_W-1:0] STEP_IDX_RST    = 3'd4;
  localparam logic [BAND_W-1:0]     BAND_IDX_RST    = 5'd8;

  localparam logic [STEP_IDX_W-1:0] STEP_COUNT = 3'd6;
  localparam logic [BAND_W-1:0]     BAND_COUNT = 5'd21;

  // status codes
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_NO_SYNTH  = 1'b1;

  typedef struct packed {
    logic                   status;
    logic [FREQ_W-1:0]      frequency_hz;
    logic [STEP_W-1:0]      step_hz;
    logic [BAND_W-1:0]      band_number;
    logic                   is_transmit;
    logic [SYNTH_W-1:0]     synth_centihz;
    logic                   pll_reset_pulse;
  } vfo_result_t;

  // step size for a step position, positions out of range read as 1 hz
  function automatic logic [STEP_W-1:0] step_hz_f(input logic [STEP_IDX_W-1:0] idx);
    logic [STEP_W-1:0] hz;
    case (idx)
      3'd2:    hz = 20'd10;
      3'd3:    hz = 20'd1000;
      3'd4:    hz = 20'd5000;
      3'd5:    hz = 20'd10000;
      3'd6:    hz = 20'd1000000;
      default: hz = 20'd1;
    endcase
    return hz;
  endfunction

  // start frequency of each band position
  function automatic logic [FREQ_W-1:0] band_freq_f(input logic [BAND_W-1:0] idx);
    logic [FREQ_W-1:0] hz;
    case (idx)
      5'd2:    hz = 28'd800000;
      5'd3:    hz = 28'd1800000;
      5'd4:    hz = 28'd3650000;
      5'd5:    hz = 28'd4985000;
      5'd6:    hz = 28'd6180000;
      5'd7:    hz = 28'd7200000;
      5'd8:    hz = 28'd10000000;
      5'd9:    hz = 28'd11780000;
      5'd10:   hz = 28'd13630000;
      5'd11:   hz = 28'd14100000;
      5'd12:   hz = 28'd15000000;
      5'd13:   hz = 28'd17655000;
      5'd14:   hz = 28'd21525000;
      5'd15:   hz = 28'd27015000;
      5'd16:   hz = 28'd28400000;
      5'd17:   hz = 28'd50000000;
      5'd18:   hz = 28'd100000000;
      5'd19:   hz = 28'd130000000;
      5'd20:   hz = 28'd144000000;
      5'd21:   hz = 28'd220000000;
      default: hz = 28'd100000;
    endcase
    return hz;
  endfunction

endpackage

@@ design/vfo_if.sv @@
// command and result channel interfaces of the vfo tuning controller
// depends on vfo_pkg
interface vfo_in_if;
  import vfo_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic                transmit;

  modport source (output valid, output operation, output transmit, input ready);
  modport sink (input valid, input operation, input transmit, output ready);
endinterface

interface vfo_out_if;
  import vfo_pkg::*;
  logic                valid;
  logic                ready;
  logic                status;
  logic [FREQ_W-1:0]   frequency_hz;
  logic [STEP_W-1:0]   step_hz;
  logic [BAND_W-1:0]   band_number;
  logic                is_transmit;
  logic [SYNTH_W-1:0]  synth_centihz;
  logic                pll_reset_pulse;

  modport source (output valid, output status, output frequency_hz, output step_hz,
                  output band_number, output is_transmit, output synth_centihz,
                  output pll_reset_pulse, input ready);
  modport sink (input valid, input status, input frequency_hz, input step_hz,
                input band_number, input is_transmit, input synth_centihz,
                input pll_reset_pulse, output ready);
endinterface

@@ design/vfo_tuning_controller_unit.sv @@
// throughput: one command per cycle while the skid register is empty, a
//   two-entry output (result register plus skid register) keeps taking
//   commands while one finished result is stalled
// reset: synchronous active-low rst_n restores tuned frequency 10 MHz, step
//   5 kHz, band 8, receive mode, default config, and empties the output
module vfo_tuning_controller_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  vfo_in_if.sink                           in_chan,
  vfo_out_if.source                        out_chan,
  input  logic                             cfg_we,
  input  logic [vfo_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vfo_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import vfo_pkg::*;

  // configuration registers
  logic [IF_W-1:0]       if_khz_r;
  logic [FREQ_W-1:0]     lower_limit_r;
  logic [FREQ_W-1:0]     upper_limit_r;
  logic                  synth_present_r;

  // tuning state
  logic [FREQ_W-1:0]     freq_r,     freq_nxt;
  logic [STEP_IDX_W-1:0] step_idx_r, step_idx_nxt;
  logic [BAND_W-1:0]     band_r,     band_nxt;
  logic                  tx_r,       tx_nxt;

  // output register and skid register
  vfo_result_t           out_r, skid_r, result;
  logic                  out_valid_r, skid_valid_r;

  logic                  in_fire, out_fire;
  logic [STEP_W-1:0]     step_cur;
  logic [FREQ_W:0]       sum_up, low_plus_step;
  logic                  pll;
  logic [SYNTH_W:0]      freq_x100, if_x100k, synth_sum;

  assign in_fire  = in_chan.valid & in_chan.ready;
  assign out_fire = out_valid_r & out_chan.ready;

  // the skid register is the only thing that can hold off a new command
  assign in_chan.ready = ~skid_valid_r;

  // ---------------------------------------------------------------------
  // configuration writes
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      if_khz_r        <= IF_KHZ_RST;
      lower_limit_r   <= LOWER_LIMIT_RST;
      upper_limit_r   <= UPPER_LIMIT_RST;
      synth_present_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IF_KHZ:        if_khz_r        <= cfg_data[IF_W-1:0];
        CFG_LOWER_LIMIT:   lower_limit_r   <= cfg_data[FREQ_W-1:0];
        CFG_UPPER_LIMIT:   upper_limit_r   <= cfg_data[FREQ_W-1:0];
        CFG_SYNTH_PRESENT: synth_present_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // next tuning state
  // ---------------------------------------------------------------------
  assign step_cur      = step_hz_f(step_idx_r);
  // one extra bit so neither sum can wrap
  assign sum_up        = {1'b0, freq_r} + {{(FREQ_W-STEP_W+1){1'b0}}, step_cur};
  assign low_plus_step = {1'b0, lower_limit_r} + {{(FREQ_W-STEP_W+1){1'b0}}, step_cur};

  always_comb begin
    freq_nxt     = freq_r;
    step_idx_nxt = step_idx_r;
    band_nxt     = band_r;
    tx_nxt       = tx_r;
    pll          = 1'b0;
    case (in_chan.operation)
      OP_TUNE_UP: begin
        // clamp at the upper limit
        if (sum_up >= {1'b0, upper_limit_r}) freq_nxt = upper_limit_r;
        else                                 freq_nxt = sum_up[FREQ_W-1:0];
      end
      OP_TUNE_DOWN: begin
        // clamp at the lower limit, never wraps below zero
        if ({1'b0, freq_r} < low_plus_step) freq_nxt = lower_limit_r;
        else freq_nxt = freq_r - {{(FREQ_W-STEP_W){1'b0}}, step_cur};
      end
      OP_NEXT_STEP: begin
        if (step_idx_r >= STEP_COUNT) step_idx_nxt = STEP_IDX_W'(1);
        else                          step_idx_nxt = step_idx_r + STEP_IDX_W'(1);
      end
      OP_NEXT_BAND: begin
        if (band_r >= BAND_COUNT) band_nxt = BAND_W'(1);
        else                      band_nxt = band_r + BAND_W'(1);
        // band start frequency is loaded without clamping
        freq_nxt = band_freq_f(band_nxt);
        pll      = 1'b1;
      end
      OP_SET_MODE: tx_nxt = in_chan.transmit;
      default: ;  // report and unused codes leave the state alone
    endcase
  end

  // ---------------------------------------------------------------------
  // result: synth = 100 * freq + 100000 * if_khz in receive, 100 * freq in
  // transmit; the two constant products run side by side
  // ---------------------------------------------------------------------
  assign freq_x100 = {{(SYNTH_W+1-FREQ_W){1'b0}}, freq_nxt} * (SYNTH_W+1)'(100);
  assign if_x100k  = tx_nxt ? '0
                   : {{(SYNTH_W+1-IF_W){1'b0}}, if_khz_r} * (SYNTH_W+1)'(100000);
  assign synth_sum = freq_x100 + if_x100k;

  always_comb begin
    if (!synth_present_r) begin
      // synthesizer absent: error status and every other field zero
      result        = '0;
      result.status = STATUS_NO_SYNTH;
    end else begin
      result.status          = STATUS_OK;
      result.frequency_hz    = freq_nxt;
      result.step_hz         = step_hz_f(step_idx_nxt);
      result.band_number     = band_nxt;
      result.is_transmit     = tx_nxt;
      result.synth_centihz   = synth_sum[SYNTH_W-1:0];
      result.pll_reset_pulse = pll;
    end
  end

  // state only moves on a command transfer with the synthesizer present
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r     <= FREQ_RST;
      step_idx_r <= STEP_IDX_RST;
      band_r     <= BAND_IDX_RST;
      tx_r       <= 1'b0;
    end else if (in_fire && synth_present_r) begin
      freq_r     <= freq_nxt;
      step_idx_r <= step_idx_nxt;
      band_r     <= band_nxt;
      tx_r       <= tx_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // output register with skid register behind it
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      // no transfer in while the skid register is full
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid_r && !out_fire) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload: skid drains into the output register, new results fill
  // whichever side is free
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (in_fire) begin
      if (out_valid_r && !out_fire) begin
        skid_r <= result;
      end else begin
        out_r <= result;
      end
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.status          = out_r.status;
  assign out_chan.frequency_hz    = out_r.frequency_hz;
  assign out_chan.step_hz         = out_r.step_hz;
  assign out_chan.band_number     = out_r.band_number;
  assign out_chan.is_transmit     = out_r.is_transmit;
  assign out_chan.synth_centihz   = out_r.synth_centihz;
  assign out_chan.pll_reset_pulse = out_r.pll_reset_pulse;

endmodule

@@ design/vfo_checker.sv @@
// port-level checker for the vfo tuning controller, with its bind
// depends on vfo_pkg and vfo_tuning_controller_unit_macros.svh
`include "vfo_tuning_controller_unit_macros.svh"

module vfo_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           status,
  input logic [vfo_pkg::FREQ_W-1:0]     frequency_hz,
  input logic [vfo_pkg::STEP_W-1:0]     step_hz,
  input logic [vfo_pkg::BAND_W-1:0]     band_number,
  input logic                           is_transmit,
  input logic [vfo_pkg::SYNTH_W-1:0]    synth_centihz,
  input logic                           pll_reset_pulse
);
  import vfo_pkg::*;

  vfo_result_t out_payload;
  logic        out_stall;
  logic        err_out;
  logic        ok_out;
  logic        rest_zero;
  logic        step_legal;
  logic        band_legal;

  assign out_payload = {status, frequency_hz, step_hz, band_number, is_transmit,
                        synth_centihz, pll_reset_pulse};
  assign out_stall   = out_valid && !out_ready;
  assign err_out     = out_valid && (status == STATUS_NO_SYNTH);
  assign ok_out      = out_valid && (status == STATUS_OK);
  assign rest_zero   = ({frequency_hz, step_hz, band_number, is_transmit,
                         synth_centihz, pll_reset_pulse} == '0);
  assign step_legal  = (step_hz == 20'd1) || (step_hz == 20'd10) || (step_hz == 20'd1000) ||
                       (step_hz == 20'd5000) || (step_hz == 20'd10000) ||
                       (step_hz == 20'd1000000);
  assign band_legal  = (band_number != '0) && (band_number <= BAND_COUNT);

  // stalled result holds still
  `VFO_ASSERT(a_out_hold, out_stall |=> out_valid && $stable(out_payload), "held result moved")

  // reset empties the output
  `VFO_ASSERT_ALWAYS(a_reset_empty, $past(!rst_n) |-> !out_valid, "valid after reset")

  // backpressure only while a result is waiting
  `VFO_ASSERT(a_ready_backpressure, !in_ready |-> out_valid, "stall with empty output")

  // error result carries nothing else
  `VFO_ASSERT(a_error_zero, err_out |-> rest_zero, "error result with nonzero fields")

  // good result shows a legal step and band
  `VFO_ASSERT(a_step_band_legal, ok_out |-> step_legal && band_legal, "illegal step or band")

endmodule

bind vfo_tuning_controller_unit vfo_checker u_vfo_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .status          (out_chan.status),
  .frequency_hz    (out_chan.frequency_hz),
  .step_hz         (out_chan.step_hz),
  .band_number     (out_chan.band_number),
  .is_transmit     (out_chan.is_transmit),
  .synth_centihz   (out_chan.synth_centihz),
  .pll_reset_pulse (out_chan.pll_reset_pulse)
);
